// ===== hdl/cpd_pkg.sv =====
// Shared types, sizes and codes of the coordinate pair deque.
`timescale 1ns / 1ps

package cpd_pkg;

  localparam int unsigned DEPTH   = 256;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned COORD_W = 16;
  localparam int unsigned PAIR_W  = 2 * COORD_W;

  typedef logic [AW-1:0]      addr_t;
  typedef logic [CW-1:0]      cnt_t;
  typedef logic [CW:0]        sum_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [PAIR_W-1:0]  pair_t;

  typedef enum logic [2:0] {
    MODE_NONE      = 3'd0,
    MODE_INS_FRONT = 3'd1,
    MODE_INS_REAR  = 3'd2,
    MODE_REM_FRONT = 3'd3,
    MODE_REM_REAR  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_e;

endpackage

// ===== hdl/cpd_if.sv =====
// Request and response channel interfaces of the coordinate pair deque.
`timescale 1ns / 1ps

interface cpd_req_if;
  logic            valid;
  logic            ready;
  logic [2:0]      mode;
  cpd_pkg::coord_t x;
  cpd_pkg::coord_t y;

  modport source (output valid, output mode, output x, output y, input ready);
  modport sink   (input valid, input mode, input x, input y, output ready);
endinterface

interface cpd_rsp_if;
  logic            valid;
  logic            ready;
  cpd_pkg::coord_t front_x;
  cpd_pkg::coord_t front_y;
  cpd_pkg::coord_t back_x;
  cpd_pkg::coord_t back_y;
  cpd_pkg::cnt_t   entries;
  logic            is_empty;
  logic [1:0]      status;

  modport source (output valid, output front_x, output front_y, output back_x,
                  output back_y, output entries, output is_empty, output status,
                  input ready);
  modport sink   (input valid, input front_x, input front_y, input back_x,
                  input back_y, input entries, input is_empty, input status,
                  output ready);
endinterface

// ===== hdl/coordinate_pair_deque_unit.sv =====
// Top level of the coordinate pair deque: pointer control, entry RAMs, response register.
// Sequence: RAM write at the accept edge, read issue in S_READ, then response load in S_LOAD,
//   which waits while the response register still holds a response that is not yet taken.
// A new request is taken only back in S_IDLE, after the last one's response is loaded; the
//   entry RAMs are a front copy and a back copy, one read port each.
// Reset: head pointer and count clear to zero, deque empty; RAM contents are not cleared.
`timescale 1ns / 1ps

module coordinate_pair_deque_unit (
  input logic      clk_i,
  input logic      rst_ni,
  cpd_req_if.sink  req_i,
  cpd_rsp_if.source rsp_o
);

  cpd_pkg::state_e state_q, state_d;
  cpd_pkg::addr_t  head_q, head_d;
  cpd_pkg::cnt_t   occ_q, occ_d;
  logic [1:0]      status_q, status_d;

  logic            rsp_valid_q, rsp_valid_d;
  cpd_pkg::coord_t front_x_q, front_y_q, back_x_q, back_y_q;
  cpd_pkg::cnt_t   entries_q;
  logic            is_empty_q;
  logic [1:0]      rsp_status_q;

  logic            req_fire;
  logic            is_full, is_none_held;
  cpd_pkg::addr_t  head_dec, head_inc, rear_pos, back_pos;
  cpd_pkg::sum_t   rear_sum, back_sum;
  logic            ram_we, ram_re, rsp_load;
  cpd_pkg::addr_t  ram_waddr;
  cpd_pkg::pair_t  ram_wdata, front_pair, back_pair;

  assign req_i.ready = (state_q == cpd_pkg::S_IDLE);
  assign req_fire    = req_i.valid & req_i.ready;

  assign is_full      = (occ_q == cpd_pkg::cnt_t'(cpd_pkg::DEPTH));
  assign is_none_held = (occ_q == '0);

  // Ring arithmetic without assuming a power-of-two depth
  assign head_dec = (head_q == '0) ? cpd_pkg::addr_t'(cpd_pkg::DEPTH - 1)
                                   : head_q - 1'b1;
  assign head_inc = (head_q == cpd_pkg::addr_t'(cpd_pkg::DEPTH - 1)) ? '0
                                   : head_q + 1'b1;
  assign rear_sum = cpd_pkg::sum_t'(head_q) + cpd_pkg::sum_t'(occ_q);
  assign rear_pos = (rear_sum >= cpd_pkg::sum_t'(cpd_pkg::DEPTH))
                    ? cpd_pkg::addr_t'(rear_sum - cpd_pkg::sum_t'(cpd_pkg::DEPTH))
                    : cpd_pkg::addr_t'(rear_sum);
  // Only used while the deque holds at least one pair
  assign back_sum = rear_sum - 1'b1;
  assign back_pos = (back_sum >= cpd_pkg::sum_t'(cpd_pkg::DEPTH))
                    ? cpd_pkg::addr_t'(back_sum - cpd_pkg::sum_t'(cpd_pkg::DEPTH))
                    : cpd_pkg::addr_t'(back_sum);

  assign ram_wdata = {req_i.x, req_i.y};
  assign rsp_load  = (state_q == cpd_pkg::S_LOAD) & (~rsp_valid_q | rsp_o.ready);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    occ_d       = occ_q;
    status_d    = status_q;
    rsp_valid_d = rsp_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = rear_pos;
    ram_re      = 1'b0;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      cpd_pkg::S_IDLE: begin
        if (req_fire) begin
          status_d = cpd_pkg::ST_OK;
          state_d  = cpd_pkg::S_READ;
          if (req_i.mode == cpd_pkg::MODE_INS_FRONT ||
              req_i.mode == cpd_pkg::MODE_INS_REAR) begin
            if (is_full) begin
              status_d = cpd_pkg::ST_FULL;
            end else begin
              ram_we = 1'b1;
              occ_d  = occ_q + 1'b1;
              if (req_i.mode == cpd_pkg::MODE_INS_FRONT) begin
                head_d    = head_dec;
                ram_waddr = head_dec;
              end
            end
          end else if (req_i.mode == cpd_pkg::MODE_REM_FRONT ||
                       req_i.mode == cpd_pkg::MODE_REM_REAR) begin
            if (is_none_held) begin
              status_d = cpd_pkg::ST_EMPTY;
            end else begin
              occ_d = occ_q - 1'b1;
              if (occ_q == cpd_pkg::cnt_t'(1)) begin
                head_d = '0;
              end else if (req_i.mode == cpd_pkg::MODE_REM_FRONT) begin
                head_d = head_inc;
              end
            end
          end
        end
      end
      cpd_pkg::S_READ: begin
        ram_re  = 1'b1;
        state_d = cpd_pkg::S_LOAD;
      end
      cpd_pkg::S_LOAD: begin
        // Hold the read data until the response register frees up
        if (rsp_load) begin
          rsp_valid_d = 1'b1;
          state_d     = cpd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cpd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpd_pkg::S_IDLE;
      head_q      <= '0;
      occ_q       <= '0;
      status_q    <= cpd_pkg::ST_OK;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      occ_q       <= occ_d;
      status_q    <= status_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      entries_q    <= occ_q;
      is_empty_q   <= is_none_held;
      rsp_status_q <= status_q;
      if (is_none_held) begin
        front_x_q <= '0;
        front_y_q <= '0;
        back_x_q  <= '0;
        back_y_q  <= '0;
      end else begin
        front_x_q <= front_pair[cpd_pkg::PAIR_W-1:cpd_pkg::COORD_W];
        front_y_q <= front_pair[cpd_pkg::COORD_W-1:0];
        back_x_q  <= back_pair[cpd_pkg::PAIR_W-1:cpd_pkg::COORD_W];
        back_y_q  <= back_pair[cpd_pkg::COORD_W-1:0];
      end
    end
  end

  // Two copies of the entries, one read port for the front and one for the back
  cpd_ram #(
    .WIDTH (cpd_pkg::PAIR_W),
    .DEPTH (cpd_pkg::DEPTH)
  ) u_front_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (front_pair)
  );

  cpd_ram #(
    .WIDTH (cpd_pkg::PAIR_W),
    .DEPTH (cpd_pkg::DEPTH)
  ) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (back_pos),
    .rdata_o (back_pair)
  );

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.front_x  = front_x_q;
  assign rsp_o.front_y  = front_y_q;
  assign rsp_o.back_x   = back_x_q;
  assign rsp_o.back_y   = back_y_q;
  assign rsp_o.entries  = entries_q;
  assign rsp_o.is_empty = is_empty_q;
  assign rsp_o.status   = rsp_status_q;

  a_occ_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= cpd_pkg::cnt_t'(cpd_pkg::DEPTH))
    else $error("occupancy beyond depth");

  a_head_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) |-> (head_q == '0))
    else $error("head pointer not cleared on empty deque");

  a_read_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == cpd_pkg::S_READ) && !req_i.ready)
    else $error("request not followed by read issue");

  a_state_changes_only_on_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cpd_pkg::S_IDLE && !req_i.valid) |=> $stable(occ_q) && $stable(head_q))
    else $error("pointer state changed without a request");

endmodule

// ===== hdl/cpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cpd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
